// ----- rtl/core/asd_pkg.sv -----
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types, constants and sensitivity tables for the shock detector.
// ----------------------------------------------------------------------------
package asd_pkg;

  localparam int SampleW  = 16;
  localparam int SensW    = 4;
  localparam int ThrW     = 10;
  localparam int LimW     = 6;
  localparam int TicksW   = 16;
  localparam int FastW    = 21;
  localparam int SlowW    = 25;
  localparam int FastShift = 4;
  localparam int SlowShift = 8;
  localparam int MeanW    = 17;
  localparam int DiffW    = 18;
  localparam int DiffSumW = 19;
  localparam int ActW     = 21;
  localparam int CntW     = 6;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [SensW-1:0]   SensMax    = 4'd8;
  localparam logic [SensW-1:0]   SensReset  = 4'd8;
  localparam logic [TicksW-1:0]  TicksReset = 16'd300;

  // register indices on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_SENSITIVITY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACT_TICKS   = 2'd1;

  typedef struct packed {
    logic [SensW-1:0]  sensitivity;
    logic [TicksW-1:0] act_ticks;
  } asd_cfg_t;

  typedef struct packed {
    logic             hit;   // sample-to-sample change above threshold
    logic [DiffW-1:0] diff;  // |slow mean - fast mean|
  } asd_axis_res_t;

  function automatic logic [ThrW-1:0] thr_lookup(input logic [SensW-1:0] sens);
    logic [ThrW-1:0] t;
    unique case (sens)
      4'd0:    t = 10'd950;
      4'd1:    t = 10'd800;
      4'd2:    t = 10'd650;
      4'd3:    t = 10'd550;
      4'd4:    t = 10'd500;
      4'd5:    t = 10'd450;
      4'd6:    t = 10'd400;
      4'd7:    t = 10'd350;
      default: t = 10'd320;
    endcase
    return t;
  endfunction

  function automatic logic [LimW-1:0] lim_lookup(input logic [SensW-1:0] sens);
    logic [LimW-1:0] l;
    unique case (sens)
      4'd0:    l = 6'd48;
      4'd1:    l = 6'd44;
      4'd2:    l = 6'd40;
      4'd3:    l = 6'd36;
      4'd4:    l = 6'd32;
      4'd5:    l = 6'd28;
      4'd6:    l = 6'd24;
      4'd7:    l = 6'd20;
      default: l = 6'd16;
    endcase
    return l;
  endfunction

endpackage

// ----- rtl/core/accel_shock_detector.sv -----
// ----------------------------------------------------------------------------
// accel_shock_detector
// Three-axis shock and activity detector, one result transaction per tick.
// ----------------------------------------------------------------------------
// Path: the input transaction is held in an input register, then in the result
//   register; out_valid rises when the result register is loaded.
// Throughput: one tick per cycle while the result is not held by out_stall.
// Reset (rst_n, synchronous): all detector state, timer and activity cleared;
//   sensitivity 8, activation ticks 300. Ready for input the cycle after.
module accel_shock_detector
  import asd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_sample_valid,
  input  logic [SampleW-1:0]  in_accel_x,
  input  logic [SampleW-1:0]  in_accel_y,
  input  logic [SampleW-1:0]  in_accel_z,

  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_shock,
  output logic [ActW-1:0]     out_activity,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  asd_cfg_t cfg;

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_smp_r;
  logic [SampleW-1:0] s1_x_r, s1_y_r, s1_z_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_shock_r;
  logic [ActW-1:0]    out_act_r;

  logic [CntW-1:0]    cnt_r,  cnt_nxt;
  logic [TicksW-1:0]  hold_r, hold_nxt;
  logic [ActW-1:0]    act_r,  act_nxt;

  logic               advance;
  logic               upd;
  logic [ThrW-1:0]    thr;
  logic [LimW-1:0]    lim;

  asd_axis_res_t      rx, ry, rz;

  logic [CntW-1:0]    cnt_dec;
  logic [CntW:0]      cnt_sum;
  logic [CntW-1:0]    cnt_wrap;
  logic               fire;
  logic [TicksW-1:0]  hold_dec;
  logic [DiffSumW-1:0] diffsum;
  logic [ActW:0]      act_calc;

  asd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // handshake: the result register frees as it is taken
  assign advance  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~advance;
  assign upd      = advance & s1_smp_r;

  assign thr = thr_lookup(cfg.sensitivity);
  assign lim = lim_lookup(cfg.sensitivity);

  asd_axis u_axis_x (.clk(clk), .rst_n(rst_n), .upd(upd), .sample(s1_x_r), .thr(thr), .res(rx));
  asd_axis u_axis_y (.clk(clk), .rst_n(rst_n), .upd(upd), .sample(s1_y_r), .thr(thr), .res(ry));
  asd_axis u_axis_z (.clk(clk), .rst_n(rst_n), .upd(upd), .sample(s1_z_r), .thr(thr), .res(rz));

  always_comb begin
    cnt_dec  = (cnt_r != '0) ? (cnt_r - 6'd1) : cnt_r;
    cnt_sum  = {1'b0, cnt_dec}
             + {{CntW-1{1'b0}}, rx.hit, 1'b0}
             + {{CntW-1{1'b0}}, ry.hit, 1'b0}
             + {{CntW-1{1'b0}}, rz.hit, 1'b0};
    cnt_wrap = cnt_sum[CntW-1:0];
    fire     = cnt_wrap > lim;

    hold_dec = (hold_r != '0) ? (hold_r - 16'd1) : hold_r;

    diffsum  = {1'b0, rx.diff} + {1'b0, ry.diff} + {1'b0, rz.diff};
    act_calc = {1'b0, act_r} - {4'd0, act_r[ActW-1:3]}
             + {{(ActW+1-DiffSumW){1'b0}}, diffsum};

    cnt_nxt  = cnt_r;
    hold_nxt = hold_dec;
    act_nxt  = act_r;
    if (s1_smp_r) begin
      cnt_nxt = fire ? '0 : cnt_wrap;
      act_nxt = act_calc[ActW-1:0];
      if (fire) begin
        hold_nxt = cfg.act_ticks;
      end
    end

    s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
    out_valid_nxt = advance ? 1'b1 : (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      hold_r      <= '0;
      act_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        cnt_r  <= cnt_nxt;
        hold_r <= hold_nxt;
        act_r  <= act_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_smp_r <= in_sample_valid;
      s1_x_r   <= in_accel_x;
      s1_y_r   <= in_accel_y;
      s1_z_r   <= in_accel_z;
    end
    if (advance) begin
      out_shock_r <= (hold_nxt != '0);
      out_act_r   <= act_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_shock    = out_shock_r;
  assign out_activity = out_act_r;

  // result register always mirrors the timer it was built from
  a_shock_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_shock_r == (hold_r != '0)))
    else $error("shock flag out of step with hold timer");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 6'd48)
    else $error("impulse counter above largest limit");

  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced transaction lost");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without back-pressure");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(act_r) && $stable(cnt_r)))
    else $error("detector state moved without a transaction");

endmodule

// ----- rtl/core/asd_cfg.sv -----
// ----------------------------------------------------------------------------
// asd_cfg
// Configuration registers: sensitivity and activation tick count.
// ----------------------------------------------------------------------------
module asd_cfg
  import asd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output asd_cfg_t            cfg_o
);

  logic [SensW-1:0]  sens_r,  sens_nxt;
  logic [TicksW-1:0] ticks_r, ticks_nxt;
  logic              wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_comb begin
    sens_nxt  = sens_r;
    ticks_nxt = ticks_r;
    if (wr) begin
      // a sensitivity whose low SensW bits exceed SensMax is dropped; upper bits are ignored
      if (cfg_index == CFG_SENSITIVITY && cfg_wdata[SensW-1:0] <= SensMax) begin
        sens_nxt = cfg_wdata[SensW-1:0];
      end
      if (cfg_index == CFG_ACT_TICKS) begin
        ticks_nxt = cfg_wdata[TicksW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r  <= SensReset;
      ticks_r <= TicksReset;
    end else begin
      sens_r  <= sens_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  assign cfg_o.sensitivity = sens_r;
  assign cfg_o.act_ticks   = ticks_r;

endmodule

// ----- rtl/core/asd_axis.sv -----
// ----------------------------------------------------------------------------
// asd_axis
// Per-axis state: previous sample, fast and slow running sums.
// ----------------------------------------------------------------------------
module asd_axis
  import asd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd,
  input  logic [SampleW-1:0] sample,
  input  logic [ThrW-1:0]    thr,
  output asd_axis_res_t      res
);

  logic [SampleW-1:0] prev_r, prev_nxt;
  logic [FastW-1:0]   fast_r, fast_nxt;
  logic [SlowW-1:0]   slow_r, slow_nxt;

  logic [SampleW:0]   step_d;
  logic [SampleW:0]   step_abs;
  logic [FastW:0]     fast_calc;
  logic [SlowW:0]     slow_calc;
  logic [MeanW-1:0]   fast_mean;
  logic [MeanW-1:0]   slow_mean;
  logic [DiffW-1:0]   mean_d;

  always_comb begin
    // change since previous sample, 17-bit two's complement
    step_d   = {sample[SampleW-1], sample} - {prev_r[SampleW-1], prev_r};
    step_abs = step_d[SampleW] ? (~step_d + 17'd1) : step_d;

    fast_calc = {fast_r[FastW-1], fast_r}
              - {{(FastShift+1){fast_r[FastW-1]}}, fast_r[FastW-1:FastShift]}
              + {{(FastW+1-SampleW){sample[SampleW-1]}}, sample};
    fast_nxt  = fast_calc[FastW-1:0];

    slow_calc = {slow_r[SlowW-1], slow_r}
              - {{(SlowShift+1){slow_r[SlowW-1]}}, slow_r[SlowW-1:SlowShift]}
              + {{(SlowW+1-SampleW){sample[SampleW-1]}}, sample};
    slow_nxt  = slow_calc[SlowW-1:0];

    // old slow mean against updated fast mean (floor shifts)
    slow_mean = slow_r[SlowW-1:SlowShift];
    fast_mean = fast_nxt[FastW-1:FastShift];
    mean_d    = {slow_mean[MeanW-1], slow_mean} - {fast_mean[MeanW-1], fast_mean};

    prev_nxt  = sample;

    res.hit   = step_abs > {{(SampleW+1-ThrW){1'b0}}, thr};
    res.diff  = mean_d[DiffW-1] ? (~mean_d + 18'd1) : mean_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      fast_r <= '0;
      slow_r <= '0;
    end else if (upd) begin
      prev_r <= prev_nxt;
      fast_r <= fast_nxt;
      slow_r <= slow_nxt;
    end
  end

endmodule
